// ===== rtl/core/qmq_pkg.sv =====
`timescale 1ns / 1ps

package qmq_pkg;

  // Default tree depth and reference resolution.
  localparam int unsigned MAX_LEVEL_DEF  = 28;
  localparam int unsigned REF_LEVELS_DEF = 30;

  // Fixed word layout of a packed quadrant.
  localparam int unsigned QUAD_W    = 64;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CODE_BITS = 56;
  localparam int unsigned COORD_W   = 30;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned ENC_LEV_W = 5;
  localparam int unsigned INDEX_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENCODE   = 3'd0,
    CMD_DECODE   = 3'd1,
    CMD_CHILD    = 3'd2,
    CMD_PARENT   = 3'd3,
    CMD_NEIGHBOR = 3'd4,
    CMD_BOUNDARY = 3'd5
  } cmd_e;

  // Kind of result carried down the pipeline.
  typedef enum logic [1:0] {
    OP_QUAD,
    OP_NEIGHBOR,
    OP_DECODE,
    OP_BOUNDARY
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [QUAD_W-1:0]    quad_a;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [ENC_LEV_W-1:0] level;
    logic [INDEX_W-1:0]   index;
  } in_item_t;

  typedef struct packed {
    logic [QUAD_W-1:0]  quad_out;
    logic [COORD_W-1:0] coord_x_out;
    logic [COORD_W-1:0] coord_y_out;
    logic               boundary_flag;
    logic               error;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic                 err;
    logic                 inc;
    logic [QUAD_W-1:0]    quad;
    logic [QUAD_W-1:0]    quad_res;
    logic [CODE_BITS-1:0] dmask;
  } s1_t;

  typedef struct packed {
    op_e                op;
    logic               err;
    logic [QUAD_W-1:0]  quad;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               bf;
  } s2_t;

endpackage

// ===== rtl/core/qmq_prep.sv =====
`timescale 1ns / 1ps

module qmq_prep #(
  parameter int unsigned MaxLevel  = qmq_pkg::MAX_LEVEL_DEF,
  parameter int unsigned RefLevels = qmq_pkg::REF_LEVELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              en_i,
  input  qmq_pkg::in_item_t item_i,
  output logic              valid_o,
  output qmq_pkg::s1_t      stage_o
);
  import qmq_pkg::*;

  localparam int unsigned Shift = RefLevels - MaxLevel;
  localparam logic [CODE_BITS-1:0] LiveMask =
      {CODE_BITS{1'b1}} >> (CODE_BITS - 2 * MaxLevel);

  logic [LEVEL_W-1:0]   lev;
  logic [LEVEL_W-1:0]   enc_lev;
  logic [CODE_BITS-1:0] code;
  logic [MaxLevel-1:0]  above;
  logic [MaxLevel-1:0]  enc_above;
  logic [MaxLevel-1:0]  par_pair;
  logic [MaxLevel-1:0]  chl_pair;
  logic [CODE_BITS-1:0] enc_code;
  logic [CODE_BITS-1:0] chl_or;
  logic [CODE_BITS-1:0] par_clr;
  logic [CODE_BITS-1:0] dmask_x;
  logic [CODE_BITS-1:0] below_bits;
  logic                 quad_ok;
  logic                 enc_bad;
  logic                 valid_q;
  s1_t                  stage_d;
  s1_t                  stage_q;

  assign lev     = item_i.quad_a[QUAD_W-1 -: LEVEL_W];
  assign code    = item_i.quad_a[CODE_BITS-1:0];
  assign enc_lev = LEVEL_W'(item_i.level);

  // Pair p of the code belongs to tree level MaxLevel - p.
  for (genvar p = 0; p < MaxLevel; p++) begin : g_pair
    assign above[p]     = lev >= LEVEL_W'(MaxLevel - p);
    assign enc_above[p] = enc_lev >= LEVEL_W'(MaxLevel - p);
    assign par_pair[p]  = lev == LEVEL_W'(MaxLevel - p);
    assign chl_pair[p]  = lev == LEVEL_W'(MaxLevel - 1 - p);

    assign chl_or[2*p +: 2]     = chl_pair[p] ? item_i.index : 2'b00;
    assign par_clr[2*p +: 2]    = {2{par_pair[p]}};
    assign dmask_x[2*p +: 2]    = {1'b0, above[p]};
    assign below_bits[2*p +: 2] = {2{~above[p]}};

    if (p + Shift < COORD_W) begin : g_enc
      assign enc_code[2*p +: 2] = enc_above[p] ?
          {item_i.coord_y[p+Shift], item_i.coord_x[p+Shift]} : 2'b00;
    end else begin : g_enc_none
      assign enc_code[2*p +: 2] = 2'b00;
    end
  end

  if (2 * MaxLevel < CODE_BITS) begin : g_upper
    assign enc_code[CODE_BITS-1:2*MaxLevel]   = '0;
    assign chl_or[CODE_BITS-1:2*MaxLevel]     = '0;
    assign par_clr[CODE_BITS-1:2*MaxLevel]    = '0;
    assign dmask_x[CODE_BITS-1:2*MaxLevel]    = '0;
    assign below_bits[CODE_BITS-1:2*MaxLevel] = '0;
  end

  assign quad_ok = (lev <= LEVEL_W'(MaxLevel)) &&
                   ((code & ~LiveMask) == '0) &&
                   ((code & below_bits) == '0);
  assign enc_bad = enc_lev > LEVEL_W'(MaxLevel);

  always_comb begin
    stage_d          = '0;
    stage_d.op       = OP_QUAD;
    stage_d.inc      = item_i.index[0];
    stage_d.quad     = item_i.quad_a;
    stage_d.dmask    = item_i.index[1] ? {dmask_x[CODE_BITS-2:0], 1'b0} : dmask_x;
    case (item_i.command)
      CMD_ENCODE: begin
        stage_d.err      = enc_bad;
        stage_d.quad_res = {enc_lev, enc_code};
      end
      CMD_DECODE: begin
        stage_d.op  = OP_DECODE;
        stage_d.err = ~quad_ok;
      end
      CMD_CHILD: begin
        stage_d.err      = ~quad_ok || (lev >= LEVEL_W'(MaxLevel));
        stage_d.quad_res = {lev + LEVEL_W'(1), code | chl_or};
      end
      CMD_PARENT: begin
        stage_d.err      = ~quad_ok || (lev == '0);
        stage_d.quad_res = {lev - LEVEL_W'(1), code & ~par_clr};
      end
      CMD_NEIGHBOR: begin
        stage_d.op  = OP_NEIGHBOR;
        stage_d.err = ~quad_ok;
      end
      CMD_BOUNDARY: begin
        stage_d.op  = OP_BOUNDARY;
        stage_d.err = ~quad_ok;
      end
      default: begin
        stage_d.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== rtl/core/qmq_exec.sv =====
`timescale 1ns / 1ps

module qmq_exec #(
  parameter int unsigned MaxLevel  = qmq_pkg::MAX_LEVEL_DEF,
  parameter int unsigned RefLevels = qmq_pkg::REF_LEVELS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic         en_i,
  input  qmq_pkg::s1_t stage_i,
  output logic         valid_o,
  output qmq_pkg::s2_t stage_o
);
  import qmq_pkg::*;

  localparam int unsigned Shift = RefLevels - MaxLevel;

  logic [CODE_BITS-1:0] code;
  logic [CODE_BITS-1:0] addend;
  logic [CODE_BITS-1:0] step;
  logic [CODE_BITS-1:0] sum;
  logic [CODE_BITS-1:0] nb_code;
  logic [COORD_W-1:0]   gx;
  logic [COORD_W-1:0]   gy;
  logic                 valid_q;
  s2_t                  stage_d;
  s2_t                  stage_q;

  assign code = stage_i.quad[CODE_BITS-1:0];

  // Decode gathers the even and odd code bits back into coordinates.
  for (genvar j = 0; j < COORD_W; j++) begin : g_gather
    if ((j >= Shift) && (j < Shift + MaxLevel)) begin : g_take
      assign gx[j] = code[2*(j-Shift)];
      assign gy[j] = code[2*(j-Shift)+1];
    end else begin : g_zero
      assign gx[j] = 1'b0;
      assign gy[j] = 1'b0;
    end
  end

  // Dilated add: the bits outside the mask are forced to one for an
  // increment so the carry ripples across them.
  assign addend  = stage_i.inc ? (code | ~stage_i.dmask) : (code & stage_i.dmask);
  assign step    = stage_i.inc ? {{(CODE_BITS-1){1'b0}}, 1'b1} : {CODE_BITS{1'b1}};
  assign sum     = addend + step;
  assign nb_code = (sum & stage_i.dmask) | (code & ~stage_i.dmask);

  always_comb begin
    stage_d     = '0;
    stage_d.op  = stage_i.op;
    stage_d.err = stage_i.err;
    stage_d.cx  = gx;
    stage_d.cy  = gy;
    stage_d.bf  = (code & stage_i.dmask) == (stage_i.inc ? stage_i.dmask : '0);
    if (stage_i.op == OP_NEIGHBOR) begin
      stage_d.quad = {stage_i.quad[QUAD_W-1:CODE_BITS], nb_code};
    end else begin
      stage_d.quad = stage_i.quad_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== rtl/core/qmq_out.sv =====
`timescale 1ns / 1ps

module qmq_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               en_i,
  input  qmq_pkg::s2_t       stage_i,
  output logic               valid_o,
  output qmq_pkg::out_item_t item_o
);
  import qmq_pkg::*;

  logic      valid_q;
  out_item_t item_d;
  out_item_t item_q;

  // Fields the command does not produce, and an error's other fields, are zero.
  always_comb begin
    item_d       = '0;
    item_d.error = stage_i.err;
    if (!stage_i.err) begin
      case (stage_i.op)
        OP_QUAD, OP_NEIGHBOR: begin
          item_d.quad_out = stage_i.quad;
        end
        OP_DECODE: begin
          item_d.coord_x_out = stage_i.cx;
          item_d.coord_y_out = stage_i.cy;
        end
        OP_BOUNDARY: begin
          item_d.boundary_flag = stage_i.bf;
        end
        default: begin
          item_d.error = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/quadtree_morton_quadrant_unit.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Signals                            | Item
// --------+-----------+------------------------------------+-------------------------
// input   | in        | in_valid_i, in_ready_o, in_item_i  | command and operands
// output  | out       | out_valid_o, out_ready_i, out_item_o | packed result and flags
//
// Every item passes three register stages: prepare (validity, level masks,
// encode, child and parent), execute (dilated add, face test, gather) and the
// output register, from which the result is offered. One item can be taken
// in every cycle; the throughput is one item per cycle while the output is
// not stalled. Reset clears only the stage valid bits. A stage advances when
// it is empty or the stage after it advances, so a stalled output holds
// every stage in place that has no empty stage after it, and no item is
// lost or repeated.

module quadtree_morton_quadrant_unit #(
  parameter int unsigned MaxLevel  = qmq_pkg::MAX_LEVEL_DEF,
  parameter int unsigned RefLevels = qmq_pkg::REF_LEVELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qmq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qmq_pkg::out_item_t out_item_o
);
  import qmq_pkg::*;

  logic v1;
  logic v2;
  logic v3;
  logic en1;
  logic en2;
  logic en3;
  s1_t  s1;
  s2_t  s2;

  // The ready chain runs back from the output: each stage loads when it
  // holds nothing or its content moves on in the same cycle.
  assign en3 = ~v3 | out_ready_i;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v3;

  // Stage one: classify the command, check the quadrant and build masks.
  qmq_prep #(
    .MaxLevel (MaxLevel),
    .RefLevels(RefLevels)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .en_i   (en1),
    .item_i (in_item_i),
    .valid_o(v1),
    .stage_o(s1)
  );

  // Stage two: neighbor add, tree face compare and coordinate gather.
  qmq_exec #(
    .MaxLevel (MaxLevel),
    .RefLevels(RefLevels)
  ) u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v1),
    .en_i   (en2),
    .stage_i(s1),
    .valid_o(v2),
    .stage_o(s2)
  );

  // Stage three: select the fields of the result and hold it for the consumer.
  qmq_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2),
    .en_i   (en3),
    .stage_i(s2),
    .valid_o(v3),
    .item_o (out_item_o)
  );

endmodule

// ===== test/quadtree_morton_quadrant_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the packed Morton quadrant unit. A short table of
// directed items comes first, then a long run of random items. Every result
// that leaves the unit is compared against the oldest expected result in a
// queue. Each expected result is typed in the directed table or computed by a
// local model of the quadrant arithmetic at the moment its item is accepted.
module quadtree_morton_quadrant_unit_test;
  import qmq_pkg::*;

  // The package enum stops at the face test. These are the two command codes
  // that the unit must reject.
  localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

  localparam int unsigned TREE_DEPTH = MAX_LEVEL_DEF;
  localparam int unsigned REF_SHIFT  = REF_LEVELS_DEF - MAX_LEVEL_DEF;
  localparam logic [QUAD_W-1:0] LEVEL_ONE = 64'd1 << CODE_BITS;
  // The x bits of the code sit on the even positions below bit 56.
  localparam logic [QUAD_W-1:0] X_BITS = 64'h0055_5555_5555_5555;

  // Quadrants used in the directed table.
  localparam logic [QUAD_W-1:0] ROOT_QUAD   = 64'h0000_0000_0000_0000;
  localparam logic [QUAD_W-1:0] DEEPEST     = 64'h1CFF_FFFF_FFFF_FFFF;
  localparam logic [QUAD_W-1:0] L1_CORNER   = 64'h01C0_0000_0000_0000;
  localparam logic [QUAD_W-1:0] L1_ORIGIN   = 64'h0100_0000_0000_0000;
  localparam logic [QUAD_W-1:0] L5_SAMPLE   = 64'h0540_0000_0000_0000;

  localparam int unsigned NUM_DIRECTED   = 25;
  localparam int unsigned NUM_RANDOM     = 2000;
  localparam int unsigned IDLE_PERCENT   = 21;
  localparam int unsigned QUIET_FIRST    = 600;
  localparam int unsigned QUIET_LAST     = 899;
  localparam int unsigned DRAIN_AT       = 1200;
  // The unit has three register stages; the settle wait catches a stray
  // result that would show up after the last expected one.
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } directed_vec_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Set during a long stretch of the random part in which neither side idles.
  bit quiet = 1'b0;

  out_item_t   pending_results[$];
  out_item_t   oldest_result;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  directed_vec_t directed_vectors [NUM_DIRECTED];

  quadtree_morton_quadrant_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #4 clk = ~clk;

  // Size of one cell at a level, in units of the finest code position.
  function automatic logic [QUAD_W-1:0] cell_size(int unsigned lev);
    return 64'd1 << (2 * (TREE_DEPTH - lev));
  endfunction

  function automatic logic [QUAD_W-1:0] spread_bits(logic [QUAD_W-1:0] v, int unsigned n);
    logic [QUAD_W-1:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[2*i] = v[i];
    return r;
  endfunction

  function automatic logic [QUAD_W-1:0] gather_even(logic [QUAD_W-1:0] v);
    logic [QUAD_W-1:0] r;
    r = '0;
    for (int i = 0; i < TREE_DEPTH; i++) r[i] = v[2*i];
    return r;
  endfunction

  // A quadrant is well formed when its level is in range and no code bit
  // lies below the bit pair of that level.
  function automatic bit quad_is_valid(logic [QUAD_W-1:0] q);
    int unsigned lev;
    lev = 32'(q[QUAD_W-1:CODE_BITS]);
    if (lev > TREE_DEPTH) return 1'b0;
    if ((q[CODE_BITS-1:0] >> (2 * TREE_DEPTH)) != '0) return 1'b0;
    return (q & (cell_size(lev) - 64'd1)) == '0;
  endfunction

  // Result that the unit owes for one item.
  function automatic out_item_t quadrant_op_result(in_item_t it);
    out_item_t         r;
    logic [QUAD_W-1:0] q, t, dmask, xs, ys, code;
    int unsigned       lev, sh;
    r   = '0;
    q   = it.quad_a;
    lev = 32'(q[QUAD_W-1:CODE_BITS]);
    if (it.command > CMD_BOUNDARY) begin
      r.error = 1'b1;
    end else if (it.command == CMD_ENCODE) begin
      if (it.level > TREE_DEPTH) begin
        r.error = 1'b1;
      end else begin
        // Only the coordinate bits that pick a cell at this level survive.
        sh   = TREE_DEPTH - 32'(it.level);
        xs   = (64'(it.coord_x) >> REF_SHIFT) >> sh;
        ys   = (64'(it.coord_y) >> REF_SHIFT) >> sh;
        code = spread_bits(xs, 32'(it.level)) | (spread_bits(ys, 32'(it.level)) << 1);
        r.quad_out = (code << (2 * sh)) | (64'(it.level) << CODE_BITS);
      end
    end else if (!quad_is_valid(q)) begin
      r.error = 1'b1;
    end else begin
      case (it.command)
        CMD_DECODE: begin
          xs = gather_even(q) << REF_SHIFT;
          ys = gather_even(q >> 1) << REF_SHIFT;
          r.coord_x_out = xs[COORD_W-1:0];
          r.coord_y_out = ys[COORD_W-1:0];
        end
        CMD_CHILD: begin
          if (lev >= TREE_DEPTH) begin
            r.error = 1'b1;
          end else begin
            t = cell_size(lev + 1);
            r.quad_out = q;
            if (it.index[0]) r.quad_out = r.quad_out | t;
            if (it.index[1]) r.quad_out = r.quad_out | (t << 1);
            r.quad_out = r.quad_out + LEVEL_ONE;
          end
        end
        CMD_PARENT: begin
          if (lev == 0) begin
            r.error = 1'b1;
          end else begin
            r.quad_out = (q & ~(64'd3 * cell_size(lev))) - LEVEL_ONE;
          end
        end
        default: begin
          // Dilated mask of the coordinate that the face moves along, kept to
          // the bits that exist at this level. Bit 1 of the face picks y.
          dmask = (X_BITS & ~(cell_size(lev) - 64'd1)) << it.index[1];
          if (it.command == CMD_NEIGHBOR) begin
            // Dilated increment or decrement; carries and borrows run off
            // the top of the mask, so the step wraps at the tree edge.
            if (it.index[0]) t = (q | ~dmask) + 64'd1;
            else t = (q & dmask) - 64'd1;
            r.quad_out = (t & dmask) | (q & ~dmask);
          end else begin
            r.boundary_flag = (q & dmask) == (it.index[0] ? dmask : 64'd0);
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t stim(logic [CMD_W-1:0] cmd, logic [QUAD_W-1:0] quad,
                                    logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                    logic [ENC_LEV_W-1:0] lev, logic [INDEX_W-1:0] idx);
    in_item_t s;
    s.command = cmd;
    s.quad_a  = quad;
    s.coord_x = cx;
    s.coord_y = cy;
    s.level   = lev;
    s.index   = idx;
    return s;
  endfunction

  function automatic out_item_t result(logic [QUAD_W-1:0] quad, logic [COORD_W-1:0] x,
                                       logic [COORD_W-1:0] y, logic bf, logic err);
    out_item_t r;
    r.quad_out      = quad;
    r.coord_x_out   = x;
    r.coord_y_out   = y;
    r.boundary_flag = bf;
    r.error         = err;
    return r;
  endfunction

  // Levels for random items lean toward the root and the deepest levels,
  // where masks and shifts reach their limits.
  function automatic int unsigned pick_level();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return TREE_DEPTH;
      2: return TREE_DEPTH - 1;
      3: return 1;
      default: return $urandom_range(0, TREE_DEPTH);
    endcase
  endfunction

  // Offers one item, with random idle cycles ahead of it, and books its
  // expected result once the unit takes it. It is always entered just after
  // a rising edge, so every drive lands at that edge.
  task automatic send_item(in_item_t s, logic typed, out_item_t want);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? want : quadrant_op_result(s));
  endtask

  // Holds the input side back until every booked result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // The receiver stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Result checker and stall watchdog. Signals are read as they stood
  // before the edge, which is when the handshake is decided.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < REPORT_LIMIT) begin
          $display("unexpected result: quad %h x %h y %h flag %b err %b",
                   out_item.quad_out, out_item.coord_x_out, out_item.coord_y_out,
                   out_item.boundary_flag, out_item.error);
        end
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.quad_out !== oldest_result.quad_out ||
            out_item.coord_x_out !== oldest_result.coord_x_out ||
            out_item.coord_y_out !== oldest_result.coord_y_out ||
            out_item.boundary_flag !== oldest_result.boundary_flag ||
            out_item.error !== oldest_result.error) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: expected quad %h x %h y %h flag %b err %b",
                     oldest_result.quad_out, oldest_result.coord_x_out,
                     oldest_result.coord_y_out, oldest_result.boundary_flag,
                     oldest_result.error);
            $display("          actual   quad %h x %h y %h flag %b err %b",
                     out_item.quad_out, out_item.coord_x_out, out_item.coord_y_out,
                     out_item.boundary_flag, out_item.error);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t          s;
    logic [QUAD_W-1:0] q;
    int unsigned       lev;

    // Directed items. Rows with a typed result are obvious from the rules:
    // errors, the root, and the all-ones deepest quadrant. The rest go
    // through the model.
    directed_vectors = '{
      // Encode at level 0 drops every coordinate bit.
      '{stim(CMD_ENCODE, '0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 5'd0, 2'd0), 1'b1,
        result(ROOT_QUAD, '0, '0, 1'b0, 1'b0)},
      // Encode at the deepest level with every coordinate bit set.
      '{stim(CMD_ENCODE, '0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 5'd28, 2'd0), 1'b1,
        result(DEEPEST, '0, '0, 1'b0, 1'b0)},
      // Encode levels past the deepest one are rejected.
      '{stim(CMD_ENCODE, '0, 30'h3FFF_FFFF, '0, 5'd29, 2'd0), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_ENCODE, '1, '0, 30'h3FFF_FFFF, 5'd31, 2'd3), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_ENCODE, '0, 30'h2AAA_AAAA, 30'h1555_5555, 5'd13, 2'd2), 1'b0, '0},
      // Decode of the root and of the deepest corner.
      '{stim(CMD_DECODE, ROOT_QUAD, '0, '0, '0, '0), 1'b1,
        result('0, '0, '0, 1'b0, 1'b0)},
      '{stim(CMD_DECODE, DEEPEST, '0, '0, '0, '0), 1'b1,
        result('0, 30'h3FFF_FFFC, 30'h3FFF_FFFC, 1'b0, 1'b0)},
      // Malformed quadrants: level too large, and a code bit below the level.
      '{stim(CMD_DECODE, 64'h1D00_0000_0000_0000, '0, '0, '0, '0), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_DECODE, 64'h0000_0000_0000_0001, '0, '0, '0, '0), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_CHILD, ROOT_QUAD, '0, '0, '0, 2'd3), 1'b1,
        result(L1_CORNER, '0, '0, 1'b0, 1'b0)},
      // A child below the deepest level does not exist.
      '{stim(CMD_CHILD, DEEPEST, '0, '0, '0, 2'd0), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_CHILD, L5_SAMPLE, '0, '0, '0, 2'd1), 1'b0, '0},
      // The root has no parent.
      '{stim(CMD_PARENT, ROOT_QUAD, '0, '0, '0, '0), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_PARENT, L1_CORNER, '0, '0, '0, '0), 1'b1,
        result(ROOT_QUAD, '0, '0, 1'b0, 1'b0)},
      '{stim(CMD_PARENT, DEEPEST, '0, '0, '0, '0), 1'b0, '0},
      // Any neighbor of the root is the root itself.
      '{stim(CMD_NEIGHBOR, ROOT_QUAD, '0, '0, '0, 2'd0), 1'b1,
        result(ROOT_QUAD, '0, '0, 1'b0, 1'b0)},
      // Steps across the tree edge wrap around.
      '{stim(CMD_NEIGHBOR, L1_ORIGIN, '0, '0, '0, 2'd0), 1'b0, '0},
      '{stim(CMD_NEIGHBOR, DEEPEST, '0, '0, '0, 2'd3), 1'b0, '0},
      '{stim(CMD_NEIGHBOR, DEEPEST, '0, '0, '0, 2'd1), 1'b0, '0},
      // The root touches every face of the tree.
      '{stim(CMD_BOUNDARY, ROOT_QUAD, '0, '0, '0, 2'd2), 1'b1,
        result('0, '0, '0, 1'b1, 1'b0)},
      '{stim(CMD_BOUNDARY, DEEPEST, '0, '0, '0, 2'd1), 1'b0, '0},
      '{stim(CMD_BOUNDARY, DEEPEST, '0, '0, '0, 2'd0), 1'b0, '0},
      // Unused command codes.
      '{stim(CMD_RESERVED_LO, DEEPEST, 30'h3FFF_FFFF, '0, 5'd3, 2'd1), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      '{stim(CMD_RESERVED_HI, ROOT_QUAD, '0, 30'h3FFF_FFFF, 5'd0, 2'd2), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)},
      // A level field of all ones is malformed for every quadrant command.
      '{stim(CMD_NEIGHBOR, 64'hFF00_0000_0000_0000, '0, '0, '0, 2'd1), 1'b1,
        result('0, '0, '0, 1'b0, 1'b1)}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_vectors[i]) begin
      send_item(directed_vectors[i].stim, directed_vectors[i].typed,
                directed_vectors[i].want);
    end
    wait_for_drain();

    // Random items. Most carry a well-formed quadrant of random content at a
    // random level; a minority are malformed in one of three ways.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet = (n >= QUIET_FIRST) && (n <= QUIET_LAST);
      if (n == DRAIN_AT) wait_for_drain();

      lev = pick_level();
      q = {$urandom, $urandom};
      q = q & ~(cell_size(lev) - 64'd1);
      q[QUAD_W-1:CODE_BITS] = LEVEL_W'(lev);
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 2))
          0: q = {$urandom, $urandom};
          1: begin
            if (lev < TREE_DEPTH) begin
              q[$urandom_range(0, 2 * (TREE_DEPTH - lev) - 1)] = 1'b1;
            end else begin
              q[QUAD_W-1:CODE_BITS] = LEVEL_W'($urandom_range(TREE_DEPTH + 1, 255));
            end
          end
          default: q[QUAD_W-1:CODE_BITS] = LEVEL_W'($urandom_range(TREE_DEPTH + 1, 255));
        endcase
      end

      if ($urandom_range(0, 99) < 4) begin
        s.command = $urandom_range(0, 1) ? CMD_RESERVED_LO : CMD_RESERVED_HI;
      end else begin
        s.command = CMD_W'($urandom_range(CMD_ENCODE, CMD_BOUNDARY));
      end
      s.quad_a  = q;
      s.coord_x = COORD_W'($urandom);
      s.coord_y = COORD_W'($urandom);
      if ($urandom_range(0, 9) == 0) s.level = ENC_LEV_W'($urandom_range(TREE_DEPTH + 1, 31));
      else s.level = ENC_LEV_W'(pick_level());
      s.index   = INDEX_W'($urandom);
      send_item(s, 1'b0, '0);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
